[sv/drp_pkg.sv]
// Package for the directory record parser: result codes, record layout offsets
// and the result word type. It has no dependencies.
package drp_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam logic [2:0] KIND_NAME       = 3'd0;
  localparam logic [2:0] KIND_RECORD     = 3'd1;
  localparam logic [2:0] KIND_ZERO_LEN   = 3'd2;
  localparam logic [2:0] KIND_BAD_LEN    = 3'd3;
  localparam logic [2:0] KIND_UNDER_FOUR = 3'd4;

  localparam logic [1:0] FORM_ORDINARY = 2'd0;
  localparam logic [1:0] FORM_DOT      = 2'd1;
  localparam logic [1:0] FORM_DOTDOT   = 2'd2;
  localparam logic [1:0] FORM_NONAME   = 2'd3;

  localparam logic [7:0]  MIN_RECORD = 8'd34;
  localparam logic [7:0]  FIXED_PART = 8'd33;
  localparam logic [11:0] YEAR_BASE  = 12'd1900;
  localparam logic [31:0] MIN_LEFT   = 32'd4;

  // Byte offsets inside a directory record.
  localparam logic [7:0] OFF_ADDR_LO = 8'd2;
  localparam logic [7:0] OFF_ADDR_HI = 8'd5;
  localparam logic [7:0] OFF_SIZE_LO = 8'd10;
  localparam logic [7:0] OFF_SIZE_HI = 8'd13;
  localparam logic [7:0] OFF_DATE_LO = 8'd18;
  localparam logic [7:0] OFF_DATE_HI = 8'd24;
  localparam logic [7:0] OFF_FLAGS   = 8'd25;
  localparam logic [7:0] OFF_NAMELEN = 8'd32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] extent_address;
    logic [31:0] file_size;
    logic [11:0] year;
    logic [47:0] stamp;
    logic [7:0]  file_flags;
    logic [7:0]  name_length;
    logic [1:0]  name_form;
    logic        last;
  } res_t;

endpackage

[sv/directory_record_parser_unit.sv]
// Directory record parser top level: byte parser and a two-word result queue.
// Depends on drp_pkg.
//
// Usage: write the directory byte size on the cfg channel (always ready), then
// send a word with in_action 0 to start a directory, followed by one word per
// extent byte with in_action 1. Each input word is handled in the cycle it is
// accepted; its results appear on the out channel in the next cycle.
// An input word gives zero, one or two result words. Name bytes come out as
// they pass; a record-complete word follows the last byte of each record, and
// a stop word ends parsing on a zero, bad or short length. Bytes sent while
// stopped give nothing.
// Throughput is one input word per cycle while out_stall is low. The queue
// holds two result words: an input word that gives two results (last name
// byte ending the record) stalls the input until its second word drains.
// When the receiver raises out_stall, the head word holds and in_stall rises
// at once (combinationally from out_stall) so no word is lost.
// Reset (rst_n low, synchronous) empties the queue, clears the register and
// the parser state and leaves the parser stopped until a start word.
module directory_record_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_name_char,
  output logic [31:0] out_extent_address,
  output logic [31:0] out_file_size,
  output logic [11:0] out_year,
  output logic [47:0] out_stamp,
  output logic [7:0]  out_file_flags,
  output logic [7:0]  out_name_length,
  output logic [1:0]  out_name_form,
  output logic        out_last
);

  logic [31:0] dir_size_r;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  rec_len_r, rec_len_nxt;
  logic [7:0]  rec_off_r, rec_off_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] size_r, size_nxt;
  logic [55:0] date_r, date_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        stopped_r, stopped_nxt;

  drp_pkg::res_t slot0_r, slot1_r;
  logic          slot0_v_r, slot1_v_r;
  drp_pkg::res_t res0, res1;
  logic [1:0]    n_res;

  logic accept, drain;

  assign cfg_ready = 1'b1;
  assign in_stall  = slot1_v_r | (slot0_v_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign drain     = slot0_v_r & ~out_stall;

  // Parser step for one input word.
  always_comb begin
    logic [2:0] code;
    logic [7:0] room;
    logic [1:0] lane4;
    logic [2:0] lane8;
    logic       is_name;
    logic       is_end;
    logic [1:0] form;
    drp_pkg::res_t rec;

    bytes_left_nxt = bytes_left_r;
    rec_len_nxt    = rec_len_r;
    rec_off_nxt    = rec_off_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    date_nxt       = date_r;
    flags_nxt      = flags_r;
    name_len_nxt   = name_len_r;
    first_nxt      = first_r;
    stopped_nxt    = stopped_r;
    res0           = '0;
    res1           = '0;
    n_res          = 2'd0;
    code           = drp_pkg::KIND_NAME;
    room           = rec_len_r - drp_pkg::FIXED_PART;
    lane4          = rec_off_r[1:0] - 2'd2;
    lane8          = 3'(5'd24 - rec_off_r[4:0]);
    is_name        = 1'b0;
    is_end         = 1'b0;
    form           = drp_pkg::FORM_ORDINARY;
    rec            = '0;

    if (in_action == drp_pkg::ACT_START) begin
      bytes_left_nxt = dir_size_r;
      rec_off_nxt    = '0;
      rec_len_nxt    = '0;
      stopped_nxt    = 1'b0;
    end else if (!stopped_r) begin
      if (rec_off_r == '0) begin
        // First byte of a record is its length.
        if (bytes_left_r < drp_pkg::MIN_LEFT) begin
          code = drp_pkg::KIND_UNDER_FOUR;
        end else if (in_data_byte == '0) begin
          code = drp_pkg::KIND_ZERO_LEN;
        end else if (in_data_byte < drp_pkg::MIN_RECORD ||
                     32'(in_data_byte) > bytes_left_r) begin
          code = drp_pkg::KIND_BAD_LEN;
        end
        if (code != drp_pkg::KIND_NAME) begin
          stopped_nxt = 1'b1;
          res0.kind   = code;
          res0.last   = 1'b1;
          n_res       = 2'd1;
        end else begin
          rec_len_nxt    = in_data_byte;
          bytes_left_nxt = bytes_left_r - 32'(in_data_byte);
          addr_nxt       = '0;
          size_nxt       = '0;
          date_nxt       = '0;
          flags_nxt      = '0;
          name_len_nxt   = '0;
          first_nxt      = '0;
          rec_off_nxt    = 8'd1;
        end
      end else begin
        if (rec_off_r >= drp_pkg::OFF_ADDR_LO && rec_off_r <= drp_pkg::OFF_ADDR_HI) begin
          addr_nxt[{lane4, 3'b000} +: 8] = in_data_byte;
        end else if (rec_off_r >= drp_pkg::OFF_SIZE_LO &&
                     rec_off_r <= drp_pkg::OFF_SIZE_HI) begin
          size_nxt[{lane4, 3'b000} +: 8] = in_data_byte;
        end else if (rec_off_r >= drp_pkg::OFF_DATE_LO &&
                     rec_off_r <= drp_pkg::OFF_DATE_HI) begin
          date_nxt[{lane8, 3'b000} +: 8] = in_data_byte;
        end else if (rec_off_r == drp_pkg::OFF_FLAGS) begin
          flags_nxt = in_data_byte;
        end else if (rec_off_r == drp_pkg::OFF_NAMELEN) begin
          name_len_nxt = (in_data_byte > room) ? room : in_data_byte;
        end else if (rec_off_r >= drp_pkg::FIXED_PART &&
                     (rec_off_r - drp_pkg::FIXED_PART) < name_len_r) begin
          is_name = 1'b1;
          if (rec_off_r == drp_pkg::FIXED_PART) begin
            first_nxt = in_data_byte;
          end
        end

        is_end = ({1'b0, rec_off_r} + 9'd1) >= {1'b0, rec_len_r};
        if (is_end) begin
          rec_off_nxt = '0;
        end else begin
          rec_off_nxt = rec_off_r + 8'd1;
        end

        if (name_len_nxt == 8'd0) begin
          form = drp_pkg::FORM_NONAME;
        end else if (name_len_nxt == 8'd1 && first_nxt == 8'd0) begin
          form = drp_pkg::FORM_DOT;
        end else if (name_len_nxt == 8'd1 && first_nxt == 8'd1) begin
          form = drp_pkg::FORM_DOTDOT;
        end

        rec.kind           = drp_pkg::KIND_RECORD;
        rec.extent_address = addr_nxt;
        rec.file_size      = size_nxt;
        rec.year           = 12'(date_nxt[55:48]) + drp_pkg::YEAR_BASE;
        rec.stamp          = date_nxt[47:0];
        rec.file_flags     = flags_nxt;
        rec.name_length    = name_len_nxt;
        rec.name_form      = form;
        rec.last           = 1'b1;

        // The name word goes first when both come from the same byte.
        if (is_name) begin
          res0.kind      = drp_pkg::KIND_NAME;
          res0.name_char = in_data_byte;
          res0.last      = ~is_end;
          if (is_end) begin
            res1  = rec;
            n_res = 2'd2;
          end else begin
            n_res = 2'd1;
          end
        end else if (is_end) begin
          res0  = rec;
          n_res = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_size_r   <= '0;
      bytes_left_r <= '0;
      rec_len_r    <= '0;
      rec_off_r    <= '0;
      addr_r       <= '0;
      size_r       <= '0;
      date_r       <= '0;
      flags_r      <= '0;
      name_len_r   <= '0;
      first_r      <= '0;
      stopped_r    <= 1'b1;
      slot0_v_r    <= 1'b0;
      slot1_v_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_size_r <= cfg_data;
      end
      if (accept) begin
        bytes_left_r <= bytes_left_nxt;
        rec_len_r    <= rec_len_nxt;
        rec_off_r    <= rec_off_nxt;
        addr_r       <= addr_nxt;
        size_r       <= size_nxt;
        date_r       <= date_nxt;
        flags_r      <= flags_nxt;
        name_len_r   <= name_len_nxt;
        first_r      <= first_nxt;
        stopped_r    <= stopped_nxt;
        slot0_v_r    <= (n_res != 2'd0);
        slot1_v_r    <= (n_res == 2'd2);
      end else if (drain) begin
        slot0_v_r <= slot1_v_r;
        slot1_v_r <= 1'b0;
      end
    end
  end

  // Queue payload; an accept only happens when the head is empty or leaving.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (drain) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_valid          = slot0_v_r;
  assign out_kind           = slot0_r.kind;
  assign out_name_char      = slot0_r.name_char;
  assign out_extent_address = slot0_r.extent_address;
  assign out_file_size      = slot0_r.file_size;
  assign out_year           = slot0_r.year;
  assign out_stamp          = slot0_r.stamp;
  assign out_file_flags     = slot0_r.file_flags;
  assign out_name_length    = slot0_r.name_length;
  assign out_name_form      = slot0_r.name_form;
  assign out_last           = slot0_r.last;

endmodule

[sv/drp_checker.sv]
// Port-level checks for the directory record parser, bound to the top level.
// Depends on drp_pkg and directory_record_parser_unit.
module drp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_name_char,
  input logic [31:0] out_extent_address,
  input logic [31:0] out_file_size,
  input logic [11:0] out_year,
  input logic        out_last
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_name_char) && $stable(out_file_size) && $stable(out_last))
    else $error("stalled result word changed");

  // Record and stop words always end the results of their input word.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != drp_pkg::KIND_NAME |-> out_last)
    else $error("non-name result without last");

  // Only record words carry record fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != drp_pkg::KIND_RECORD |->
      out_extent_address == '0 && out_file_size == '0 && out_year == '0)
    else $error("record fields set on a non-record word");

  // Only name words carry a name byte.
  a_name_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != drp_pkg::KIND_NAME |-> out_name_char == '0)
    else $error("name byte set on a non-name word");

  // A record year never lies below the base year.
  a_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == drp_pkg::KIND_RECORD |-> out_year >= drp_pkg::YEAR_BASE)
    else $error("record year below base");

endmodule

bind directory_record_parser_unit drp_checker u_drp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_name_char      (out_name_char),
  .out_extent_address (out_extent_address),
  .out_file_size      (out_file_size),
  .out_year           (out_year),
  .out_last           (out_last)
);
